FILE: sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 subnet membership table package
// Shared types, codes and the prefix mask function of the table.
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

   // Table size default for the top level parameter
   localparam int DEFAULT_TABLE_DEPTH = 16;

   // Address and prefix constants
   localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [5:0]  MAX_PREFIX    = 6'd32;

   // Operation codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CHECK = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_DONE       = 2'd0;
   localparam logic [1:0] STAT_BAD_PREFIX = 2'd1;
   localparam logic [1:0] STAT_FULL       = 2'd2;

   // Request word
   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] address;
      logic [5:0]  prefix_len;
   } req_type;

   // Response word
   typedef struct packed {
      logic       matched;
      logic [1:0] status;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_SCAN,
      CTL_DRAIN
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic do_add;
      logic do_clear;
      logic scan_clear;
      logic scan_step;
      logic respond;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic op_check;
      logic empty;
      logic scan_last;
   } stat_type;

   // Mask with the upper p bits set
   function automatic logic [31:0] prefix_mask(input logic [5:0] p);
      logic [31:0] mask;
      begin
         if (p == 6'd0) begin
            mask = 32'd0;
         end else if (p >= MAX_PREFIX) begin
            mask = ADDR_ALL_ONES;
         end else begin
            mask = ~(ADDR_ALL_ONES >> p);
         end
         return mask;
      end
   endfunction

endpackage : ist_pkg

`default_nettype wire

FILE: sv/ipv4_subnet_membership_table.sv
// Add, clear and a check on an empty table respond from the execute state.
// A check on a filled table responds from the drain state after a scan;
// the table is scanned one entry per cycle through the entry memory's read port.
// A new word is taken only once busy falls, so one word finishes before the next.
// Reset (synchronous, active high) empties the table; the receiver cannot stall.
// ----------------------------------------------------------------------------
// IPv4 subnet membership table
// Keeps monitored networks and answers add, check and clear words.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_subnet_membership_table
   import ist_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // Sequence each word
   ist_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Store entries and compute the answer
   ist_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // An accepted word keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // A response only follows work in progress
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a word in progress");

   // A failed add never reports a match
   a_status_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.matched && (rsp_data.status != STAT_DONE)))
      else $error("match reported together with an add failure");
`endif

endmodule : ipv4_subnet_membership_table

`default_nettype wire

FILE: sv/ist_ctrl.sv
// ----------------------------------------------------------------------------
// IPv4 subnet membership table controller
// Sequences capture, table update, table scan and response of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_ctrl
   import ist_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (start) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            if (stat.op_check && !stat.empty) begin
               state_in = CTL_SCAN;
            end else begin
               state_in = CTL_IDLE;
            end
         end
         CTL_SCAN: begin
            if (stat.scan_last) begin
               state_in = CTL_DRAIN;
            end
         end
         CTL_DRAIN: begin
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         CTL_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         CTL_EXEC: begin
            if (stat.op_check && !stat.empty) begin
               cmd.scan_clear = 1'b1;
            end else begin
               cmd.do_add   = 1'b1;
               cmd.do_clear = 1'b1;
               cmd.respond  = 1'b1;
            end
         end
         CTL_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         CTL_DRAIN: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule : ist_ctrl

`default_nettype wire

FILE: sv/ist_dpath.sv
// ----------------------------------------------------------------------------
// IPv4 subnet membership table datapath
// Holds the entry memory, the fill count, the scan index and the response.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_dpath
   import ist_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output stat_type     stat,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Entry memory: prefix length over masked network
   logic [37:0] mem [0:TABLE_DEPTH-1];
   logic [37:0] rd_data_ff;

   req_type     req_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] idx_ff;
   logic        cmp_valid_ff;
   logic        hit_ff;
   logic        strobe_ff;
   rsp_type     rsp_ff;

   logic [CNT_W-1:0] idx_ext;
   logic        is_add;
   logic        is_check;
   logic        is_clear;
   logic        bad_prefix;
   logic        full;
   logic        add_ok;
   logic        cur_hit;
   logic [31:0] add_network;
   rsp_type     rsp_in;

   // Decode the captured word
   always_comb begin
      is_add      = (req_ff.operation == OP_ADD);
      is_check    = (req_ff.operation == OP_CHECK);
      is_clear    = (req_ff.operation == OP_CLEAR);
      bad_prefix  = (req_ff.prefix_len == 6'd0) || (req_ff.prefix_len > MAX_PREFIX);
      full        = (count_ff == CNT_W'(TABLE_DEPTH));
      add_ok      = is_add && !bad_prefix && !full;
      add_network = req_ff.address & prefix_mask(req_ff.prefix_len);
      idx_ext     = CNT_W'(idx_ff);
      cur_hit     = cmp_valid_ff &&
                    ((req_ff.address & prefix_mask(rd_data_ff[37:32])) == rd_data_ff[31:0]);
   end

   // Status to the controller
   always_comb begin
      stat.op_check  = is_check;
      stat.empty     = (count_ff == '0);
      stat.scan_last = ((idx_ext + CNT_W'(1)) == count_ff);
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // Write a new entry
   always_ff @(posedge clock) begin
      if (cmd.do_add && add_ok) begin
         mem[count_ff[IDX_W-1:0]] <= {req_ff.prefix_len, add_network};
      end
   end

   // Read the entry under the scan index
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[idx_ff];
   end

   // Advance the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.do_clear && is_clear) begin
         count_ff <= '0;
      end else if (cmd.do_add && add_ok) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Walk the table and collect hits
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else if (cmd.scan_clear) begin
         idx_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff       <= idx_ff + IDX_W'(1);
         cmp_valid_ff <= 1'b1;
         hit_ff       <= hit_ff | cur_hit;
      end else begin
         cmp_valid_ff <= 1'b0;
      end
   end

   // Form the response word
   always_comb begin
      rsp_in.matched = is_check && ((count_ff == '0) || hit_ff || cur_hit);
      if (is_add && bad_prefix) begin
         rsp_in.status = STAT_BAD_PREFIX;
      end else if (is_add && full) begin
         rsp_in.status = STAT_FULL;
      end else begin
         rsp_in.status = STAT_DONE;
      end
   end

   // Present the response for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule : ist_dpath

`default_nettype wire
